/* rtl/multi_slot_repeating_timeout_table_core_macros.svh */
// assertion macros for the timeout table checker
`ifndef MULTI_SLOT_REPEATING_TIMEOUT_TABLE_CORE_MACROS_SVH
`define MULTI_SLOT_REPEATING_TIMEOUT_TABLE_CORE_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define MRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define MRTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/mrtt_pkg.sv */
// package: beat types, slot record, op and kind codes for the timeout table
`timescale 1ns / 1ps
`default_nettype none

package mrtt_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_REGISTER    = 3'd1;
  localparam logic [2:0] OP_CLEAR       = 3'd2;
  localparam logic [2:0] OP_START       = 3'd3;
  localparam logic [2:0] OP_STOP_RESET  = 3'd4;
  localparam logic [2:0] OP_EDIT_DELAY  = 3'd5;
  localparam logic [2:0] OP_RESET_DELAY = 3'd6;

  localparam logic [1:0] KIND_DONE     = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
  localparam logic [1:0] KIND_CALLOUT  = 2'd2;
  localparam logic [1:0] KIND_FINAL    = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [6:0]  timeout_count;
    logic [6:0]  callout_count;
    logic [6:0]  timeout_amount;
    logic [6:0]  callout_amount;
    logic [15:0] delay;
    logic        start_now;
    logic        timeout_event_enable;
    logic        callout_event_enable;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] event_id;
    logic [2:0] slot;
    logic       found;
    logic       last;
  } evt_t;

  typedef struct packed {
    logic [7:0]  id;
    logic        running;
    logic [15:0] delay_value;
    logic [15:0] tick_left;
    logic [6:0]  timeouts_left;
    logic [6:0]  callouts_left;
    logic [6:0]  timeout_reload;
    logic [6:0]  callout_reload;
    logic        en_timeout;
    logic        en_callout;
  } slot_rec_t;

endpackage

`default_nettype wire

/* rtl/multi_slot_repeating_timeout_table_core.sv */
// Repeating timeout table: a ring of slot cells walked by one head controller.
// cmd channel (cmd_valid/cmd_stall/cmd) takes one op per beat: tick, register,
// clear, start, stop_reset, edit_delay or reset_delay. evt channel
// (evt_valid/evt_stall/evt) returns results; the final result of an op has
// last set. A tick returns one event beat per firing slot, then a tick-done
// beat; every other op returns one beat with the found flag and the slot.
// The slot records sit in a ring of SLOTS cells. An op rotates the ring once:
// while the output is not stalled, each cycle the head cell is read, updated
// and written back at the tail. The final beat of an op is registered after
// the walk, and the next op is accepted only once the controller is idle.
// cmd_stall is high while an op is in flight; one op is worked at a time.
// A single output register holds each result; while evt_stall holds it, the
// ring walk pauses and resumes when the beat is taken. The next op may be
// accepted while the last result still waits in the output register.
// Reset clears all slots (free, stopped, all counters zero).
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_repeating_timeout_table_core
  import mrtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic evt_valid,
  input  logic evt_stall,
  output evt_t evt
);

  localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  cmd_t           item;
  logic           matched;
  logic [2:0]     match_slot;

  slot_rec_t      ring [SLOTS];
  slot_rec_t      rec_next;
  logic           hit;
  logic [1:0]     ev_kind;
  logic [7:0]     want;

  logic can_emit, step_walk, done_step, emit;

  assign can_emit  = !evt_valid || !evt_stall;
  assign step_walk = (state == S_WALK) && can_emit;
  assign done_step = (state == S_DONE) && can_emit;
  assign emit      = (step_walk && (ev_kind != KIND_DONE)) || done_step;
  assign cmd_stall = (state != S_IDLE);

  for (genvar g = 0; g < SLOTS; g++) begin : g_ring
    slot_rec_t nb;
    if (g == SLOTS - 1) begin : g_tail
      assign nb = rec_next;
    end else begin : g_mid
      assign nb = ring[g+1];
    end
    mrtt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step_walk),
      .d     (nb),
      .q     (ring[g])
    );
  end

  // head cell update
  always_comb begin
    rec_next = ring[0];
    hit      = 1'b0;
    ev_kind  = KIND_DONE;
    want     = (item.op == OP_REGISTER) ? 8'h00 : item.id;
    if (item.op == OP_TICK) begin
      if ((ring[0].id != 8'h00) && ring[0].running) begin
        if (ring[0].tick_left != 16'h0000) begin
          rec_next.tick_left = ring[0].tick_left - 16'd1;
        end else begin
          rec_next.tick_left = ring[0].delay_value;
          if (ring[0].timeouts_left != 7'd0) begin
            rec_next.timeouts_left = ring[0].timeouts_left - 7'd1;
            if (ring[0].en_timeout) ev_kind = KIND_TIMEOUT;
          end else begin
            rec_next.timeouts_left = ring[0].timeout_reload;
            if (ring[0].callouts_left != 7'd0) begin
              rec_next.callouts_left = ring[0].callouts_left - 7'd1;
              if (ring[0].en_callout) ev_kind = KIND_CALLOUT;
            end else begin
              rec_next.running       = 1'b0;
              rec_next.callouts_left = ring[0].callout_reload;
              if (ring[0].en_callout) ev_kind = KIND_FINAL;
            end
          end
        end
      end
    end else if ((item.op <= OP_RESET_DELAY) && !matched && (ring[0].id == want)) begin
      hit = 1'b1;
      unique case (item.op)
        OP_REGISTER: begin
          rec_next.id             = item.id;
          rec_next.running        = item.start_now;
          rec_next.delay_value    = item.delay;
          rec_next.tick_left      = item.delay;
          rec_next.timeouts_left  = item.timeout_count;
          rec_next.callouts_left  = item.callout_count;
          rec_next.timeout_reload = item.timeout_amount;
          rec_next.callout_reload = item.callout_amount;
          rec_next.en_timeout     = item.timeout_event_enable;
          rec_next.en_callout     = item.callout_event_enable;
        end
        OP_CLEAR: begin
          rec_next = '0;
        end
        OP_START: begin
          rec_next.running = 1'b1;
        end
        OP_STOP_RESET: begin
          rec_next.running       = 1'b0;
          rec_next.tick_left     = ring[0].delay_value;
          rec_next.timeouts_left = ring[0].timeout_reload;
          rec_next.callouts_left = ring[0].callout_reload;
        end
        OP_EDIT_DELAY: begin
          rec_next.delay_value = item.delay;
          rec_next.tick_left   = item.delay;
        end
        default: begin
          rec_next.tick_left     = ring[0].delay_value;
          rec_next.timeouts_left = ring[0].timeout_reload;
        end
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      matched   <= 1'b0;
      evt_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        evt_valid <= emit;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state   <= S_WALK;
            cnt     <= '0;
            matched <= 1'b0;
          end
        end
        S_WALK: begin
          if (step_walk) begin
            if (hit) matched <= 1'b1;
            if (cnt == CNT_LAST) begin
              state <= S_DONE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (can_emit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid) begin
      item <= cmd;
    end
    if (step_walk && hit) begin
      match_slot <= 3'(cnt);
    end
    if (step_walk && (ev_kind != KIND_DONE)) begin
      evt.kind     <= ev_kind;
      evt.event_id <= ring[0].id;
      evt.slot     <= 3'(cnt);
      evt.found    <= 1'b1;
      evt.last     <= 1'b0;
    end else if (done_step) begin
      evt.kind <= KIND_DONE;
      evt.last <= 1'b1;
      if (item.op == OP_TICK) begin
        evt.event_id <= 8'h00;
        evt.slot     <= 3'd0;
        evt.found    <= 1'b0;
      end else begin
        evt.event_id <= item.id;
        evt.slot     <= matched ? match_slot : 3'd0;
        evt.found    <= matched;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mrtt_cell.sv */
// one ring cell holding the state of a single timer slot
`timescale 1ns / 1ps
`default_nettype none

module mrtt_cell
  import mrtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  slot_rec_t d,
  output slot_rec_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mrtt_checker.sv */
// port-level checker for the timeout table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_repeating_timeout_table_core_macros.svh"

module mrtt_checker
  import mrtt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic evt_valid,
  input logic evt_stall,
  input evt_t evt
);

  `MRTT_ASSERT_NEXT(a_evt_hold, evt_valid && evt_stall, evt_valid && $stable(evt), "stalled evt beat changed")
  `MRTT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "no stall after cmd beat")
  `MRTT_ASSERT_SAME(a_busy_cause, $rose(cmd_stall), $past(cmd_valid && !cmd_stall), "stall rose without cmd beat")
  `MRTT_ASSERT_SAME(a_free_with_last, $fell(cmd_stall), evt_valid && evt.last, "stall fell without last beat")

endmodule

bind multi_slot_repeating_timeout_table_core mrtt_checker u_mrtt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt)
);

`default_nettype wire
